// ===== rtl/nbge_pkg.sv =====
// Shared types and constants for the n-body gravity Euler step unit.
package nbge_pkg;

   // Fixed field widths of the body data.
   localparam int POS_W  = 48;
   localparam int MASS_W = 40;
   localparam int ACC_W  = 64;
   localparam int DT_W   = 32;
   localparam int WIDE_W = 128;

   // Operation codes carried by an input transfer.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // Pairs closer than this distance (Q.24) are skipped.
   localparam logic [63:0] MIN_DIST = 64'd1678;

   // Operations of the shared arithmetic unit.
   typedef enum logic [1:0] {
      ARITH_MUL,
      ARITH_DIV,
      ARITH_SQRT
   } arith_op_type;

   typedef struct packed {
      arith_op_type        op;
      logic [WIDE_W-1:0]   a;
      logic [WIDE_W-1:0]   b;
   } arith_cmd_type;

   // Configuration values handed from the register bank to the sequencer.
   typedef struct packed {
      logic [31:0] gravity;
      logic [31:0] softening;
      logic [6:0]  body_count;
   } csr_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CLEAR,
      ST_PA_I,
      ST_PA_J,
      ST_PA_D,
      ST_SQ,
      ST_ROOT,
      ST_CHECK,
      ST_FORCE,
      ST_MASS_I,
      ST_MASS_J,
      ST_MASS_C,
      ST_AX_MUL,
      ST_AX_DIV,
      ST_AX_MJ,
      ST_AX_MI,
      ST_ACC_I,
      ST_ACC_IW,
      ST_ACC_J,
      ST_ACC_JW,
      ST_U_RD,
      ST_U_MA,
      ST_U_MV
   } seq_state_type;

endpackage

// ===== rtl/nbge_arith.sv =====
// Shared iterative arithmetic unit: 64x64 multiply, 128-bit divide, square root.
module nbge_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  nbge_pkg::arith_cmd_type cmd,
   output logic                   done,
   output logic [127:0]           result
);
   import nbge_pkg::*;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   arith_op_type    op_ff, op_in;
   logic [7:0]      cnt_ff, cnt_in;
   logic [127:0]    a_ff, a_in;
   logic [127:0]    b_ff, b_in;
   logic [127:0]    acc_ff, acc_in;
   logic [127:0]    rem_ff, rem_in;

   logic [31:0]     a_half, b_half;
   logic [63:0]     pp;
   logic [127:0]    pp_sh;
   logic [128:0]    dtrial, ddiff;
   logic            dge;
   logic [67:0]     srem, strial, sdiff;
   logic            sge;
   logic [7:0]      last_cnt;

   // One 32x32 partial product a cycle, placed by the half indices.
   always_comb begin
      a_half = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp     = 64'(a_half) * 64'(b_half);
      if (cnt_ff[1] && cnt_ff[0]) begin
         pp_sh = {pp, 64'b0};
      end else if (cnt_ff[1] || cnt_ff[0]) begin
         pp_sh = {32'b0, pp, 32'b0};
      end else begin
         pp_sh = {64'b0, pp};
      end
   end

   // Restoring division: one quotient bit a cycle.
   always_comb begin
      dtrial = {rem_ff, a_ff[127]};
      dge    = dtrial >= {1'b0, b_ff};
      ddiff  = dtrial - {1'b0, b_ff};
   end

   // Digit-by-digit square root: one root bit a cycle.
   always_comb begin
      srem   = {rem_ff[65:0], a_ff[127:126]};
      strial = {2'b0, acc_ff[63:0], 2'b01};
      sge    = srem >= strial;
      sdiff  = srem - strial;
   end

   always_comb begin
      case (op_ff)
         ARITH_MUL:  last_cnt = 8'd3;
         ARITH_DIV:  last_cnt = 8'd127;
         ARITH_SQRT: last_cnt = 8'd63;
         default:    last_cnt = 8'd3;
      endcase
   end

   // Next-value logic for the iteration registers.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            op_in   = cmd.op;
            cnt_in  = 8'd0;
            a_in    = cmd.a;
            b_in    = cmd.b;
            acc_in  = '0;
            rem_in  = '0;
         end
      end else begin
         case (op_ff)
            ARITH_MUL: begin
               acc_in = acc_ff + pp_sh;
            end
            ARITH_DIV: begin
               rem_in = dge ? ddiff[127:0] : dtrial[127:0];
               acc_in = {acc_ff[126:0], dge};
               a_in   = {a_ff[126:0], 1'b0};
            end
            ARITH_SQRT: begin
               rem_in = {60'b0, (sge ? sdiff : srem)};
               acc_in = {64'b0, acc_ff[62:0], sge};
               a_in   = {a_ff[125:0], 2'b0};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff + 8'd1;
         if (cnt_ff == last_cnt) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ARITH_MUL;
         cnt_ff  <= 8'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// ===== rtl/nbge_seq.sv =====
// Step sequencer with the body tables, driving the shared arithmetic unit.
module nbge_seq #(
   parameter int MAX_BODIES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nbge_pkg::csr_type        cfg,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_operation,
   input  logic [5:0]              req_body_index,
   input  logic signed [47:0]      req_pos_x,
   input  logic signed [47:0]      req_pos_y,
   input  logic signed [47:0]      req_pos_z,
   input  logic signed [47:0]      req_vel_x,
   input  logic signed [47:0]      req_vel_y,
   input  logic signed [47:0]      req_vel_z,
   input  logic [39:0]             req_body_mass,
   input  logic [31:0]             req_step_time,
   output logic                    ar_start,
   output nbge_pkg::arith_cmd_type ar_cmd,
   input  logic                    ar_done,
   input  logic [127:0]            ar_result,
   output logic                    rsp_valid,
   output logic [5:0]              rsp_out_index,
   output logic signed [47:0]      rsp_new_pos_x,
   output logic signed [47:0]      rsp_new_pos_y,
   output logic signed [47:0]      rsp_new_pos_z,
   output logic signed [47:0]      rsp_new_vel_x,
   output logic signed [47:0]      rsp_new_vel_y,
   output logic signed [47:0]      rsp_new_vel_z,
   output logic                    rsp_last_body
);
   import nbge_pkg::*;

   localparam int IDX_W     = $clog2(MAX_BODIES);
   localparam int CNT_W     = $clog2(MAX_BODIES + 1);
   localparam int ACC_DEPTH = 3 * MAX_BODIES;
   localparam int ADDR_W    = $clog2(ACC_DEPTH);

   // Saturate a magnitude to 63 bits and apply the sign.
   function automatic logic signed [63:0] sat64(input logic [127:0] m, input logic neg);
      logic [62:0] v;
      v = (|m[127:63]) ? '1 : m[62:0];
      return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

   function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic signed [47:0] clamp48(input logic signed [63:0] x);
      if (!((x[63:47] == '0) || (x[63:47] == '1))) begin
         return x[63] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      end
      return x[47:0];
   endfunction

   function automatic logic signed [63:0] sext48(input logic signed [47:0] v);
      return {{16{v[47]}}, v};
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   // Table address of axis k of body b: 3*b + k.
   function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] b,
                                                 input logic [1:0] k);
      logic [ADDR_W+1:0] t;
      t = (ADDR_W+2)'(b) + ((ADDR_W+2)'(b) << 1) + (ADDR_W+2)'(k);
      return t[ADDR_W-1:0];
   endfunction

   seq_state_type         state_ff, state_in;
   logic [1:0]            k_ff, k_in;
   logic [CNT_W-1:0]      i_ff, i_in;
   logic [CNT_W-1:0]      j_ff, j_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic                  pend_ff, pend_in;
   logic [31:0]           dt_ff, dt_in;
   logic [5:0]            ld_idx_ff, ld_idx_in;
   logic signed [47:0]    ld_pos_ff [3];
   logic signed [47:0]    ld_pos_in [3];
   logic signed [47:0]    ld_vel_ff [3];
   logic signed [47:0]    ld_vel_in [3];
   logic [39:0]           ld_mass_ff, ld_mass_in;
   logic signed [47:0]    pi_ff, pi_in;
   logic [48:0]           dmag_ff [3];
   logic [48:0]           dmag_in [3];
   logic                  dneg_ff [3];
   logic                  dneg_in [3];
   logic [127:0]          sum_ff, sum_in;
   logic [63:0]           dist_ff, dist_in;
   logic [63:0]           force_ff, force_in;
   logic [127:0]          tmp_ff, tmp_in;
   logic [63:0]           c_ff, c_in;
   logic [39:0]           mi_ff, mi_in;
   logic [39:0]           mj_ff, mj_in;
   logic signed [63:0]    ai_ff, ai_in;
   logic signed [63:0]    aj_ff, aj_in;
   logic signed [47:0]    vnew_ff, vnew_in;
   logic signed [47:0]    opos_ff [3];
   logic signed [47:0]    opos_in [3];
   logic signed [47:0]    ovel_ff [3];
   logic signed [47:0]    ovel_in [3];
   logic                  rv_ff, rv_in;
   logic [5:0]            oidx_ff, oidx_in;
   logic                  olast_ff, olast_in;

   // Body tables.
   logic signed [47:0]    pos_mem_ff [ACC_DEPTH];
   logic signed [47:0]    vel_mem_ff [ACC_DEPTH];
   logic [39:0]           mass_mem_ff [MAX_BODIES];
   logic signed [63:0]    acc_mem_ff [ACC_DEPTH];
   logic signed [47:0]    pos_rd_ff, vel_rd_ff;
   logic [39:0]           mass_rd_ff;
   logic signed [63:0]    acc_rd_ff;
   logic [ADDR_W-1:0]     pos_ra, vel_ra, acc_ra, pos_wa, vel_wa, acc_wa;
   logic [IDX_W-1:0]      mass_ra, mass_wa;
   logic                  pos_we, vel_we, mass_we, acc_we;
   logic signed [47:0]    pos_wd, vel_wd;
   logic [39:0]           mass_wd;
   logic signed [63:0]    acc_wd;

   logic [ADDR_W-1:0]     addr_i, addr_j, addr_ld;
   logic signed [48:0]    d_diff;
   logic signed [47:0]    vel_c, pos_c;
   logic [6:0]            n_clamp;
   logic                  ld_ok;
   logic                  j_more, i_more;

   assign addr_i  = addr_of(i_ff, k_ff);
   assign addr_j  = addr_of(j_ff, k_ff);
   assign addr_ld = addr_of(CNT_W'(ld_idx_ff), k_ff);
   assign d_diff  = {pos_rd_ff[47], pos_rd_ff} - {pi_ff[47], pi_ff};
   assign vel_c   = clamp48(add_sat(sext48(vel_rd_ff),
                                    sat64(ar_result >> 24, acc_rd_ff[63])));
   assign pos_c   = clamp48(add_sat(sext48(pos_rd_ff),
                                    sat64(ar_result >> 24, vnew_ff[47])));
   assign n_clamp = (cfg.body_count > 7'(MAX_BODIES)) ? 7'(MAX_BODIES) : cfg.body_count;
   assign ld_ok   = {1'b0, ld_idx_ff} < 7'(MAX_BODIES);
   assign j_more  = ((CNT_W+1)'(j_ff) + 1'b1) < (CNT_W+1)'(n_ff);
   assign i_more  = ((CNT_W+1)'(i_ff) + 2'd2) < (CNT_W+1)'(n_ff);

   // Next state, datapath next values, table ports and arithmetic requests.
   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      n_in       = n_ff;
      clr_in     = clr_ff;
      pend_in    = pend_ff;
      dt_in      = dt_ff;
      ld_idx_in  = ld_idx_ff;
      ld_pos_in  = ld_pos_ff;
      ld_vel_in  = ld_vel_ff;
      ld_mass_in = ld_mass_ff;
      pi_in      = pi_ff;
      dmag_in    = dmag_ff;
      dneg_in    = dneg_ff;
      sum_in     = sum_ff;
      dist_in    = dist_ff;
      force_in   = force_ff;
      tmp_in     = tmp_ff;
      c_in       = c_ff;
      mi_in      = mi_ff;
      mj_in      = mj_ff;
      ai_in      = ai_ff;
      aj_in      = aj_ff;
      vnew_in    = vnew_ff;
      opos_in    = opos_ff;
      ovel_in    = ovel_ff;
      rv_in      = 1'b0;
      oidx_in    = oidx_ff;
      olast_in   = olast_ff;

      pos_ra  = addr_i;
      vel_ra  = addr_i;
      acc_ra  = addr_i;
      mass_ra = i_ff[IDX_W-1:0];
      pos_we  = 1'b0;
      vel_we  = 1'b0;
      mass_we = 1'b0;
      acc_we  = 1'b0;
      pos_wa  = addr_i;
      vel_wa  = addr_i;
      acc_wa  = addr_i;
      mass_wa = ld_idx_ff[IDX_W-1:0];
      pos_wd  = pos_c;
      vel_wd  = vnew_ff;
      mass_wd = ld_mass_ff;
      acc_wd  = '0;

      ar_start   = 1'b0;
      ar_cmd.op  = ARITH_MUL;
      ar_cmd.a   = '0;
      ar_cmd.b   = '0;

      // A request is issued whenever none is pending; the state then waits for done.
      case (state_ff)
         ST_SQ, ST_AX_MUL, ST_AX_MJ, ST_AX_MI, ST_U_MA, ST_U_MV, ST_ROOT, ST_FORCE,
         ST_AX_DIV: begin
            if (!pend_ff) begin
               ar_start = 1'b1;
               pend_in  = 1'b1;
            end else if (ar_done) begin
               pend_in  = 1'b0;
            end
         end
         default: begin
            pend_in = pend_ff;
         end
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dt_in      = req_step_time;
               ld_idx_in  = req_body_index;
               ld_pos_in  = '{req_pos_x, req_pos_y, req_pos_z};
               ld_vel_in  = '{req_vel_x, req_vel_y, req_vel_z};
               ld_mass_in = req_body_mass;
               k_in       = 2'd0;
               if (req_operation == OP_STEP) begin
                  n_in     = CNT_W'(n_clamp);
                  clr_in   = '0;
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         // Writes the axes of one body in turn, unless the index is out of range.
         ST_LOAD: begin
            pos_wa  = addr_ld;
            vel_wa  = addr_ld;
            pos_wd  = ld_pos_ff[k_ff];
            vel_wd  = ld_vel_ff[k_ff];
            pos_we  = ld_ok;
            vel_we  = ld_ok;
            mass_we = ld_ok && (k_ff == 2'd0);
            if (!ld_ok || k_ff == 2'd2) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         // Sweep the acceleration table to zero.
         ST_CLEAR: begin
            acc_we = 1'b1;
            acc_wa = clr_ff;
            acc_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(ACC_DEPTH - 1)) begin
               i_in = '0;
               k_in = 2'd0;
               if (n_ff >= CNT_W'(2)) begin
                  j_in     = CNT_W'(1);
                  state_in = ST_PA_I;
               end else if (n_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_U_RD;
               end
            end
         end
         ST_PA_I: begin
            pos_ra   = addr_i;
            state_in = ST_PA_J;
         end
         ST_PA_J: begin
            pi_in    = pos_rd_ff;
            pos_ra   = addr_j;
            state_in = ST_PA_D;
         end
         ST_PA_D: begin
            dneg_in[k_ff] = d_diff[48];
            dmag_in[k_ff] = d_diff[48] ? 49'(-d_diff) : 49'(d_diff);
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               sum_in   = '0;
               state_in = ST_SQ;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_PA_I;
            end
         end
         // Squared distance, one axis at a time.
         ST_SQ: begin
            ar_cmd.op = ARITH_MUL;
            ar_cmd.a  = 128'(dmag_ff[k_ff]);
            ar_cmd.b  = 128'(dmag_ff[k_ff]);
            if (pend_ff && ar_done) begin
               sum_in = sum_ff + ar_result;
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_ROOT;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         ST_ROOT: begin
            ar_cmd.op = ARITH_SQRT;
            ar_cmd.a  = sum_ff;
            if (pend_ff && ar_done) begin
               dist_in  = ar_result[63:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (dist_ff < MIN_DIST) begin
               k_in = 2'd0;
               if (j_more) begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_PA_I;
               end else if (i_more) begin
                  i_in     = i_ff + 1'b1;
                  j_in     = i_ff + CNT_W'(2);
                  state_in = ST_PA_I;
               end else begin
                  i_in     = '0;
                  state_in = ST_U_RD;
               end
            end else begin
               state_in = ST_FORCE;
            end
         end
         // Force magnitude G / (d^2 + softening).
         ST_FORCE: begin
            ar_cmd.op = ARITH_DIV;
            ar_cmd.a  = 128'(cfg.gravity) << 48;
            ar_cmd.b  = sum_ff + (128'(cfg.softening) << 24);
            if (pend_ff && ar_done) begin
               force_in = ar_result[63:0];
               state_in = ST_MASS_I;
            end
         end
         ST_MASS_I: begin
            mass_ra  = i_ff[IDX_W-1:0];
            state_in = ST_MASS_J;
         end
         ST_MASS_J: begin
            mi_in    = mass_rd_ff;
            mass_ra  = j_ff[IDX_W-1:0];
            state_in = ST_MASS_C;
         end
         ST_MASS_C: begin
            mj_in    = mass_rd_ff;
            k_in     = 2'd0;
            state_in = ST_AX_MUL;
         end
         // Per axis: |d| * f / dist, then times each mass.
         ST_AX_MUL: begin
            ar_cmd.op = ARITH_MUL;
            ar_cmd.a  = 128'(dmag_ff[k_ff]);
            ar_cmd.b  = 128'(force_ff);
            if (pend_ff && ar_done) begin
               tmp_in   = ar_result;
               state_in = ST_AX_DIV;
            end
         end
         ST_AX_DIV: begin
            ar_cmd.op = ARITH_DIV;
            ar_cmd.a  = tmp_ff;
            ar_cmd.b  = 128'(dist_ff);
            if (pend_ff && ar_done) begin
               c_in     = ar_result[63:0];
               state_in = ST_AX_MJ;
            end
         end
         ST_AX_MJ: begin
            ar_cmd.op = ARITH_MUL;
            ar_cmd.a  = 128'(c_ff);
            ar_cmd.b  = 128'(mj_ff);
            if (pend_ff && ar_done) begin
               ai_in    = sat64(ar_result >> 16, dneg_ff[k_ff]);
               state_in = ST_AX_MI;
            end
         end
         ST_AX_MI: begin
            ar_cmd.op = ARITH_MUL;
            ar_cmd.a  = 128'(c_ff);
            ar_cmd.b  = 128'(mi_ff);
            if (pend_ff && ar_done) begin
               aj_in    = sat64(ar_result >> 16, !dneg_ff[k_ff]);
               state_in = ST_ACC_I;
            end
         end
         ST_ACC_I: begin
            acc_ra   = addr_i;
            state_in = ST_ACC_IW;
         end
         ST_ACC_IW: begin
            acc_we   = 1'b1;
            acc_wa   = addr_i;
            acc_wd   = add_sat(acc_rd_ff, ai_ff);
            state_in = ST_ACC_J;
         end
         ST_ACC_J: begin
            acc_ra   = addr_j;
            state_in = ST_ACC_JW;
         end
         ST_ACC_JW: begin
            acc_we = 1'b1;
            acc_wa = addr_j;
            acc_wd = add_sat(acc_rd_ff, aj_ff);
            if (k_ff != 2'd2) begin
               k_in     = k_ff + 2'd1;
               state_in = ST_AX_MUL;
            end else begin
               k_in = 2'd0;
               if (j_more) begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_PA_I;
               end else if (i_more) begin
                  i_in     = i_ff + 1'b1;
                  j_in     = i_ff + CNT_W'(2);
                  state_in = ST_PA_I;
               end else begin
                  i_in     = '0;
                  state_in = ST_U_RD;
               end
            end
         end
         // Integration: velocity first, then position from the new velocity.
         ST_U_RD: begin
            state_in = ST_U_MA;
         end
         ST_U_MA: begin
            ar_cmd.op = ARITH_MUL;
            ar_cmd.a  = 128'(mag64(acc_rd_ff));
            ar_cmd.b  = 128'(dt_ff);
            if (pend_ff && ar_done) begin
               vnew_in  = vel_c;
               state_in = ST_U_MV;
            end
         end
         ST_U_MV: begin
            ar_cmd.op = ARITH_MUL;
            ar_cmd.a  = 128'(mag64(sext48(vnew_ff)));
            ar_cmd.b  = 128'(dt_ff);
            if (pend_ff && ar_done) begin
               pos_we        = 1'b1;
               vel_we        = 1'b1;
               opos_in[k_ff] = pos_c;
               ovel_in[k_ff] = vnew_ff;
               if (k_ff == 2'd2) begin
                  rv_in    = 1'b1;
                  oidx_in  = 6'(i_ff);
                  olast_in = ((CNT_W+1)'(i_ff) + 1'b1) == (CNT_W+1)'(n_ff);
                  k_in     = 2'd0;
                  i_in     = i_ff + 1'b1;
                  state_in = olast_in ? ST_IDLE : ST_U_RD;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_U_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
   end

   // Loop counters and datapath registers.
   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      n_ff       <= n_in;
      clr_ff     <= clr_in;
      dt_ff      <= dt_in;
      ld_idx_ff  <= ld_idx_in;
      ld_pos_ff  <= ld_pos_in;
      ld_vel_ff  <= ld_vel_in;
      ld_mass_ff <= ld_mass_in;
      pi_ff      <= pi_in;
      dmag_ff    <= dmag_in;
      dneg_ff    <= dneg_in;
      sum_ff     <= sum_in;
      dist_ff    <= dist_in;
      force_ff   <= force_in;
      tmp_ff     <= tmp_in;
      c_ff       <= c_in;
      mi_ff      <= mi_in;
      mj_ff      <= mj_in;
      ai_ff      <= ai_in;
      aj_ff      <= aj_in;
      vnew_ff    <= vnew_in;
      opos_ff    <= opos_in;
      ovel_ff    <= ovel_in;
      oidx_ff    <= oidx_in;
      olast_ff   <= olast_in;
   end

   // Table write and registered read ports.
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem_ff[pos_wa] <= pos_wd;
      end
      if (vel_we) begin
         vel_mem_ff[vel_wa] <= vel_wd;
      end
      if (mass_we) begin
         mass_mem_ff[mass_wa] <= mass_wd;
      end
      if (acc_we) begin
         acc_mem_ff[acc_wa] <= acc_wd;
      end
      pos_rd_ff  <= pos_mem_ff[pos_ra];
      vel_rd_ff  <= vel_mem_ff[vel_ra];
      mass_rd_ff <= mass_mem_ff[mass_ra];
      acc_rd_ff  <= acc_mem_ff[acc_ra];
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rv_ff;
   assign rsp_out_index = oidx_ff;
   assign rsp_new_pos_x = opos_ff[0];
   assign rsp_new_pos_y = opos_ff[1];
   assign rsp_new_pos_z = opos_ff[2];
   assign rsp_new_vel_x = ovel_ff[0];
   assign rsp_new_vel_y = ovel_ff[1];
   assign rsp_new_vel_z = ovel_ff[2];
   assign rsp_last_body = olast_ff;

endmodule

// ===== rtl/nbody_gravity_euler_step_unit.sv =====
// Top level of the n-body gravity Euler step unit: register bank and core.
//
//   Channel   Direction  Handshake                   Payload
//   request   in         start high while busy low   req_operation .. req_step_time
//   result    out        rsp_valid for one cycle     rsp_out_index .. rsp_last_body
//   csr       in/out     psel, penable, pwrite       paddr, pwdata, prdata
//
// A load writes one body into the tables. A step first clears the
// acceleration table, then works through each body pair (a pair that is too
// close skips the force work) and then updates each body; the shared
// multiply/divide/root unit does every product, quotient and root in turn.
// Reset is synchronous and returns the block to idle.
// Results leave on a single-cycle strobe; the receiver cannot stall them.
module nbody_gravity_euler_step_unit #(
   parameter int MAX_BODIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic [5:0]         req_body_index,
   input  logic signed [47:0] req_pos_x,
   input  logic signed [47:0] req_pos_y,
   input  logic signed [47:0] req_pos_z,
   input  logic signed [47:0] req_vel_x,
   input  logic signed [47:0] req_vel_y,
   input  logic signed [47:0] req_vel_z,
   input  logic [39:0]        req_body_mass,
   input  logic [31:0]        req_step_time,
   output logic               rsp_valid,
   output logic [5:0]         rsp_out_index,
   output logic signed [47:0] rsp_new_pos_x,
   output logic signed [47:0] rsp_new_pos_y,
   output logic signed [47:0] rsp_new_pos_z,
   output logic signed [47:0] rsp_new_vel_x,
   output logic signed [47:0] rsp_new_vel_y,
   output logic signed [47:0] rsp_new_vel_z,
   output logic               rsp_last_body,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import nbge_pkg::*;

   localparam logic [1:0]  CSR_GRAVITY    = 2'd0;
   localparam logic [1:0]  CSR_SOFTENING  = 2'd1;
   localparam logic [1:0]  CSR_BODY_COUNT = 2'd2;
   localparam logic [31:0] GRAVITY_RESET  = 32'd16777216;
   localparam logic [31:0] SOFT_RESET     = 32'd16777;

   logic [31:0]    gravity_ff;
   logic [31:0]    soft_ff;
   logic [6:0]     count_ff;
   csr_type        cfg;
   logic           ar_start;
   arith_cmd_type  ar_cmd;
   logic           ar_done;
   logic [127:0]   ar_result;

   // Register writes complete in the access phase of a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= GRAVITY_RESET;
         soft_ff    <= SOFT_RESET;
         count_ff   <= 7'd0;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            CSR_GRAVITY:    gravity_ff <= pwdata;
            CSR_SOFTENING:  soft_ff    <= pwdata;
            CSR_BODY_COUNT: count_ff   <= pwdata[6:0];
            default:        count_ff   <= count_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_GRAVITY:    prdata = gravity_ff;
         CSR_SOFTENING:  prdata = soft_ff;
         CSR_BODY_COUNT: prdata = 32'(count_ff);
         default:        prdata = '0;
      endcase
   end

   assign pready         = 1'b1;
   assign cfg.gravity    = gravity_ff;
   assign cfg.softening  = soft_ff;
   assign cfg.body_count = count_ff;

   nbge_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (ar_start),
      .cmd    (ar_cmd),
      .done   (ar_done),
      .result (ar_result)
   );

   nbge_seq #(
      .MAX_BODIES (MAX_BODIES)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_body_index (req_body_index),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_vel_x      (req_vel_x),
      .req_vel_y      (req_vel_y),
      .req_vel_z      (req_vel_z),
      .req_body_mass  (req_body_mass),
      .req_step_time  (req_step_time),
      .ar_start       (ar_start),
      .ar_cmd         (ar_cmd),
      .ar_done        (ar_done),
      .ar_result      (ar_result),
      .rsp_valid      (rsp_valid),
      .rsp_out_index  (rsp_out_index),
      .rsp_new_pos_x  (rsp_new_pos_x),
      .rsp_new_pos_y  (rsp_new_pos_y),
      .rsp_new_pos_z  (rsp_new_pos_z),
      .rsp_new_vel_x  (rsp_new_vel_x),
      .rsp_new_vel_y  (rsp_new_vel_y),
      .rsp_new_vel_z  (rsp_new_vel_z),
      .rsp_last_body  (rsp_last_body)
   );

endmodule

// ===== rtl/nbge_port_checker.sv =====
// Port-level checks on the n-body step unit, bound to the top level.
module nbge_port_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last_body
);

   // Every accepted transfer makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not make the block busy");

   // Results are spread out by the integration work between them.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results on consecutive cycles");

   // Only the final body of a step may appear once the block is free.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_body |-> busy)
      else $error("non-final result while idle");

   // The block frees up with the final result of a step.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_body |-> !busy)
      else $error("still busy at the final result");

endmodule

bind nbody_gravity_euler_step_unit nbge_port_checker u_port_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the n-body gravity Euler step unit.
`timescale 1ns / 100ps

module testbench;
   import nbge_pkg::*;

   // Register byte addresses on the configuration port.
   localparam logic [3:0] ADDR_GRAVITY   = 4'd0;
   localparam logic [3:0] ADDR_SOFTENING = 4'd4;
   localparam logic [3:0] ADDR_COUNT     = 4'd8;
   localparam logic [3:0] ADDR_UNUSED    = 4'd12;

   localparam int      NBODIES    = 64;
   localparam longint  CYCLE_LIMIT = 8000000;
   localparam longint  SAT64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint  SAT64_MIN  = 64'sh8000_0000_0000_0000;
   localparam longint  SAT48_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint  SAT48_MIN  = 64'shFFFF_8000_0000_0000;
   localparam logic [63:0] CLOSE_LIMIT = 64'd1678;

   typedef logic signed [2:0][47:0] vec3_type;

   typedef struct packed {
      logic [5:0] index;
      vec3_type   pos;
      vec3_type   vel;
      logic       last;
   } body_report_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_operation;
   logic [5:0] req_body_index;
   logic signed [47:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [47:0] req_vel_x, req_vel_y, req_vel_z;
   logic [39:0] req_body_mass;
   logic [31:0] req_step_time;
   logic rsp_valid;
   logic [5:0] rsp_out_index;
   logic signed [47:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_pos_z;
   logic signed [47:0] rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z;
   logic rsp_last_body;
   logic psel, penable, pwrite;
   logic [3:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   nbody_gravity_euler_step_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_body_index(req_body_index),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_vel_z(req_vel_z),
      .req_body_mass(req_body_mass), .req_step_time(req_step_time),
      .rsp_valid(rsp_valid), .rsp_out_index(rsp_out_index),
      .rsp_new_pos_x(rsp_new_pos_x), .rsp_new_pos_y(rsp_new_pos_y),
      .rsp_new_pos_z(rsp_new_pos_z), .rsp_new_vel_x(rsp_new_vel_x),
      .rsp_new_vel_y(rsp_new_vel_y), .rsp_new_vel_z(rsp_new_vel_z),
      .rsp_last_body(rsp_last_body),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Predictor state: configuration and body table.
   logic [31:0] gravity_q24;
   logic [31:0] soften_q24;
   logic [6:0]  count_reg;
   longint      pos_table [3*NBODIES];
   longint      vel_table [3*NBODIES];
   logic [39:0] mass_table [NBODIES];

   body_report_type expected_reports [$];
   int  mismatch_count;
   int  error_count;
   bit  steady;
   longint cycle_count = 0;

   // Clock.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Fixed-point helpers of the predictor.
   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint sat_signed(logic [127:0] m, bit neg);
      logic [63:0] v;
      v = (m[127:64] != 0 || m[63:0] > 64'(SAT64_MAX)) ? 64'(SAT64_MAX) : m[63:0];
      return neg ? -longint'(v) : longint'(v);
   endfunction

   function automatic longint add_sat(longint a, longint b);
      longint r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63])
         r = a[63] ? SAT64_MIN : SAT64_MAX;
      return r;
   endfunction

   function automatic longint clamp48(longint v);
      return v > SAT48_MAX ? SAT48_MAX : (v < SAT48_MIN ? SAT48_MIN : v);
   endfunction

   function automatic longint scale_by_dt(longint x, logic [31:0] dt);
      logic [127:0] prod;
      prod = {64'b0, magnitude(x)} * {96'b0, dt};
      return sat_signed(prod >> 24, x < 0);
   endfunction

   function automatic logic [63:0] root_floor(logic [127:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (x >= {64'b0, c} * {64'b0, c})
            r = c;
      end
      return r;
   endfunction

   // One integration step over the body table, queuing the reports it causes.
   function automatic void predict_step(logic [31:0] dt);
      longint accel [3*NBODIES];
      longint d [3];
      logic [127:0] dist_sq, denom;
      logic [63:0] span, pull, c;
      int n;
      bit neg;
      longint v, p;
      body_report_type rep;
      n = count_reg > NBODIES ? NBODIES : count_reg;
      for (int k = 0; k < 3*NBODIES; k++)
         accel[k] = 0;
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            dist_sq = 0;
            for (int k = 0; k < 3; k++) begin
               d[k] = pos_table[3*j+k] - pos_table[3*i+k];
               dist_sq += {64'b0, magnitude(d[k])} * {64'b0, magnitude(d[k])};
            end
            span = root_floor(dist_sq);
            // Pairs that are too close add nothing.
            if (span < CLOSE_LIMIT)
               continue;
            denom = dist_sq + ({96'b0, soften_q24} << 24);
            pull = 64'(({96'b0, gravity_q24} << 48) / denom);
            for (int k = 0; k < 3; k++) begin
               c = 64'(({64'b0, magnitude(d[k])} * {64'b0, pull}) / {64'b0, span});
               neg = d[k] < 0;
               accel[3*i+k] = add_sat(accel[3*i+k],
                  sat_signed(({64'b0, c} * {88'b0, mass_table[j]}) >> 16, neg));
               accel[3*j+k] = add_sat(accel[3*j+k],
                  sat_signed(({64'b0, c} * {88'b0, mass_table[i]}) >> 16, !neg));
            end
         end
      end
      // Semi-implicit Euler update and one report per body.
      for (int i = 0; i < n; i++) begin
         rep.index = 6'(i);
         for (int k = 0; k < 3; k++) begin
            v = clamp48(add_sat(vel_table[3*i+k], scale_by_dt(accel[3*i+k], dt)));
            p = clamp48(add_sat(pos_table[3*i+k], scale_by_dt(v, dt)));
            vel_table[3*i+k] = v;
            pos_table[3*i+k] = p;
            rep.pos[k] = p[47:0];
            rep.vel[k] = v[47:0];
         end
         rep.last = (i + 1 == n);
         expected_reports = {expected_reports, rep};
      end
   endfunction

   // Result checker.
   always @(posedge clock) begin
      body_report_type got, want;
      if (!reset && rsp_valid) begin
         got.index = rsp_out_index;
         got.pos   = {rsp_new_pos_z, rsp_new_pos_y, rsp_new_pos_x};
         got.vel   = {rsp_new_vel_z, rsp_new_vel_y, rsp_new_vel_x};
         got.last  = rsp_last_body;
         if (expected_reports.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result transfer for body %0d", got.index);
         end else begin
            want = expected_reports.pop_front();
            if (got !== want) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch on body %0d: expected idx %0d pos %h vel %h last %b",
                     want.index, want.index, want.pos, want.vel, want.last);
                  $display("   actual idx %0d pos %h vel %h last %b",
                     got.index, got.pos, got.vel, got.last);
               end
            end
         end
      end
   end

   // Sends one item and lowers start once the transfer has taken place.
   task automatic send_item(input logic op, input logic [5:0] idx, input vec3_type p,
                            input vec3_type v, input logic [39:0] m, input logic [31:0] dt);
      while (!steady && $urandom_range(0, 99) < 33) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start          <= 1'b1;
      req_operation  <= op;
      req_body_index <= idx;
      {req_pos_z, req_pos_y, req_pos_x} <= p;
      {req_vel_z, req_vel_y, req_vel_x} <= v;
      req_body_mass  <= m;
      req_step_time  <= dt;
      do
         @(posedge clock);
      while (busy);
      if (op == OP_LOAD) begin
         for (int k = 0; k < 3; k++) begin
            pos_table[3*idx+k] = longint'($signed(p[k]));
            vel_table[3*idx+k] = longint'($signed(v[k]));
         end
         mass_table[idx] = m;
      end else begin
         predict_step(dt);
      end
      @(negedge clock);
      start <= 1'b0;
   endtask

   function automatic logic [47:0] random48(bit full);
      logic [63:0] r;
      r = {$urandom, $urandom};
      return full ? r[47:0] : {{16{r[31]}}, r[31:0]} >>> $urandom_range(0, 8);
   endfunction

   function automatic vec3_type random_vec(bit full);
      return {random48(full), random48(full), random48(full)};
   endfunction

   function automatic logic [39:0] random_mass();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return $urandom_range(0, 3) == 0 ? r[39:0] : 40'(r[23:0]);
   endfunction

   task automatic load_body(input logic [5:0] idx, input vec3_type p, input vec3_type v,
                            input logic [39:0] m);
      send_item(OP_LOAD, idx, p, v, m, $urandom);
   endtask

   task automatic run_step(input logic [31:0] dt);
      send_item(OP_STEP, 6'($urandom), random_vec(1), random_vec(1), random_mass(), dt);
   endtask

   // Lowers start, waits for every expected result and for the block to settle.
   task automatic wait_quiet();
      @(negedge clock);
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (expected_reports.size() != 0 || busy)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      case (addr)
         ADDR_GRAVITY:   gravity_q24 = data;
         ADDR_SOFTENING: soften_q24  = data;
         ADDR_COUNT:     count_reg   = data[6:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // A step with the reset body count reports nothing.
   task automatic test_zero_bodies();
      run_step(32'h0100_0000);
      wait_quiet();
   endtask

   // Field extremes, saturation and dt at both ends.
   task automatic test_extremes();
      csr_write(ADDR_COUNT, 32'd3);
      load_body(6'd0, {3{48'sh7FFF_FFFF_FFFF}}, {3{48'sh7FFF_FFFF_FFFF}}, 40'hFF_FFFF_FFFF);
      load_body(6'd1, {3{48'sh8000_0000_0000}}, {3{48'sh8000_0000_0000}}, 40'hFF_FFFF_FFFF);
      load_body(6'd2, '0, '0, '0);
      run_step(32'hFFFF_FFFF);
      run_step(32'h0);
      wait_quiet();
   endtask

   // Close pair, huge constant with no softening, then the opposite settings.
   task automatic test_close_pair();
      csr_write(ADDR_GRAVITY, 32'hFFFF_FFFF);
      csr_write(ADDR_SOFTENING, 32'h0);
      load_body(6'd0, {3{48'sh0000_0100_0000}}, '0, 40'hFF_FFFF_FFFF);
      load_body(6'd1, {3{48'sh0000_0100_0001}}, '0, 40'hFF_FFFF_FFFF);
      load_body(6'd2, {48'sh0, 48'sh0, 48'sh0000_0200_0000}, '0, 40'h01_0000);
      run_step(32'h0100_0000);
      wait_quiet();
      csr_write(ADDR_GRAVITY, 32'h0);
      csr_write(ADDR_SOFTENING, 32'hFFFF_FFFF);
      run_step(32'h0080_0000);
      wait_quiet();
   endtask

   // A write to an unused address changes nothing.
   task automatic test_unused_register();
      csr_write(ADDR_GRAVITY, 32'h0100_0000);
      csr_write(ADDR_UNUSED, $urandom);
      run_step(32'h0010_0000);
      wait_quiet();
   endtask

   // Full table, all bodies at one point so every pair is skipped cheaply;
   // counts at and above the table size.
   task automatic test_count_cap();
      vec3_type spot;
      spot = random_vec(0);
      steady = 1'b1;
      for (int i = 0; i < NBODIES; i++)
         load_body(6'(i), spot, random_vec(0), random_mass());
      steady = 1'b0;
      csr_write(ADDR_COUNT, 32'd64);
      run_step(32'h0);
      wait_quiet();
      csr_write(ADDR_COUNT, 32'd127);
      run_step($urandom);
      wait_quiet();
   endtask

   // Random phases: new settings, fresh bodies, then one or two steps.
   task automatic test_random();
      int n;
      logic [31:0] g, s;
      for (int phase = 0; phase < 20; phase++) begin
         steady = (phase == 5 || phase == 6);
         case ($urandom_range(0, 3))
            0: g = 32'hFFFF_FFFF;
            1: g = 32'h0;
            2: g = $urandom;
            default: g = 32'(1) << $urandom_range(16, 28);
         endcase
         s = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000);
         n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 6);
         if (phase == 10)
            n = 12;
         csr_write(ADDR_GRAVITY, g);
         csr_write(ADDR_SOFTENING, s);
         csr_write(ADDR_COUNT, 32'(n));
         for (int i = 0; i < n + $urandom_range(0, 2); i++)
            load_body(6'(i), random_vec($urandom_range(0, 4) == 0), random_vec(0),
                      random_mass());
         repeat ($urandom_range(1, 2))
            run_step($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000));
         wait_quiet();
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_LOAD;
      req_body_index = '0;
      {req_pos_x, req_pos_y, req_pos_z} = '0;
      {req_vel_x, req_vel_y, req_vel_z} = '0;
      req_body_mass = '0;
      req_step_time = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      gravity_q24 = 32'd16777216;
      soften_q24 = 32'd16777;
      count_reg = '0;
      for (int k = 0; k < 3*NBODIES; k++) begin
         pos_table[k] = 0;
         vel_table[k] = 0;
      end
      for (int k = 0; k < NBODIES; k++)
         mass_table[k] = '0;
      mismatch_count = 0;
      error_count = 0;
      steady = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_bodies();
      test_extremes();
      test_close_pair();
      test_unused_register();
      test_count_cap();
      test_random();

      wait_quiet();
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_reports.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/nbge_pkg.sv
rtl/nbge_arith.sv
rtl/nbge_seq.sv
rtl/nbody_gravity_euler_step_unit.sv
rtl/nbge_port_checker.sv
verif/testbench.sv
